/* sv/lls_pkg.sv */
`timescale 1ns / 1ps

package lls_pkg;

   localparam int MAX_SERVERS_DEF = 16;

   // slot numbers are carried at a fixed width that covers up to 256 slots
   localparam int SLOT_W    = 8;
   localparam int CMD_W     = 3;
   localparam int KEY_W     = 10;
   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int CLIENTS_W = 16;
   localparam int HB_W      = 4;
   localparam int STATUS_W  = 2;

   localparam logic [HB_W-1:0]      HB_MAX        = '1;
   localparam logic [HB_W-1:0]      HB_LIMIT_RST  = 4'd2;
   localparam logic [CLIENTS_W-1:0] CLIENTS_MAX   = '1;

   localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_KEEPALIVE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_BUMP   = 3'd1,
      OP_REVIVE = 3'd2,
      OP_DROP   = 3'd3,
      OP_AGE    = 3'd4
   } op_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic                 hit;
      logic [SLOT_W-1:0]    hit_idx;
      logic                 free;
      logic [SLOT_W-1:0]    free_idx;
      logic                 best;
      logic [SLOT_W-1:0]    best_idx;
      logic [CLIENTS_W-1:0] best_clients;
      logic [KEY_W-1:0]     best_key;
      logic [ADDR_W-1:0]    best_addr;
      logic [PORT_W-1:0]    best_port;
   } token_type;

   // update broadcast to all cells
   typedef struct packed {
      logic              en;
      op_type            op;
      logic [SLOT_W-1:0] idx;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
   } apply_type;

endpackage

/* sv/lls_req_if.sv */
`timescale 1ns / 1ps

interface lls_req_if;
   logic                          valid;
   logic                          ready;
   logic [lls_pkg::CMD_W-1:0]     command;
   logic [lls_pkg::KEY_W-1:0]     conn_id;
   logic [lls_pkg::ADDR_W-1:0]    server_addr;
   logic [lls_pkg::PORT_W-1:0]    server_port;

   modport source (output valid, command, conn_id, server_addr, server_port, input ready);
   modport sink   (input valid, command, conn_id, server_addr, server_port, output ready);
endinterface

/* sv/lls_rsp_if.sv */
`timescale 1ns / 1ps

interface lls_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            ack;
   logic [lls_pkg::STATUS_W-1:0]    status;
   logic [lls_pkg::ADDR_W-1:0]      assigned_addr;
   logic [lls_pkg::PORT_W-1:0]      assigned_port;
   logic [lls_pkg::CLIENTS_W-1:0]   assigned_clients;

   modport source (output valid, ack, status, assigned_addr, assigned_port, assigned_clients,
                   input ready);
   modport sink   (input valid, ack, status, assigned_addr, assigned_port, assigned_clients,
                   output ready);
endinterface

/* sv/lls_cell.sv */
`timescale 1ns / 1ps

module lls_cell #(
   parameter logic [lls_pkg::SLOT_W-1:0] SLOT_IDX = '0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lls_pkg::token_type          tok_prev,
   output lls_pkg::token_type          tok_next,
   input  lls_pkg::apply_type          apply,
   input  logic [lls_pkg::HB_W-1:0]    hb_limit
);

   logic                               valid_ff, valid_in;
   logic                               alive_ff, alive_in;
   logic [lls_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [lls_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [lls_pkg::PORT_W-1:0]         port_ff, port_in;
   logic [lls_pkg::CLIENTS_W-1:0]      clients_ff, clients_in;
   logic [lls_pkg::HB_W-1:0]           hb_ff, hb_in;
   logic [lls_pkg::HB_W-1:0]           hb_up;
   lls_pkg::token_type                 token_ff, token_in;
   logic                               sel;

   assign tok_next = token_ff;

   always_comb begin
      token_in = tok_prev;
      if (valid_ff && key_ff == tok_prev.key && !tok_prev.hit) begin
         token_in.hit     = 1'b1;
         token_in.hit_idx = SLOT_IDX;
      end
      if (!valid_ff && !tok_prev.free) begin
         token_in.free     = 1'b1;
         token_in.free_idx = SLOT_IDX;
      end
      if (valid_ff && alive_ff &&
          (!tok_prev.best || clients_ff < tok_prev.best_clients ||
           (clients_ff == tok_prev.best_clients && key_ff < tok_prev.best_key))) begin
         token_in.best         = 1'b1;
         token_in.best_idx     = SLOT_IDX;
         token_in.best_clients = clients_ff;
         token_in.best_key     = key_ff;
         token_in.best_addr    = addr_ff;
         token_in.best_port    = port_ff;
      end
   end

   assign sel   = apply.en && apply.idx == SLOT_IDX;
   assign hb_up = (hb_ff == lls_pkg::HB_MAX) ? hb_ff : hb_ff + 1'b1;

   always_comb begin
      valid_in   = valid_ff;
      alive_in   = alive_ff;
      key_in     = key_ff;
      addr_in    = addr_ff;
      port_in    = port_ff;
      clients_in = clients_ff;
      hb_in      = hb_ff;
      if (apply.en) begin
         case (apply.op)
            lls_pkg::OP_WRITE: begin
               if (sel) begin
                  valid_in   = 1'b1;
                  alive_in   = 1'b1;
                  key_in     = apply.key;
                  addr_in    = apply.addr;
                  port_in    = apply.port;
                  clients_in = '0;
                  hb_in      = '0;
               end
            end
            lls_pkg::OP_BUMP: begin
               if (sel && clients_ff != lls_pkg::CLIENTS_MAX) begin
                  clients_in = clients_ff + 1'b1;
               end
            end
            lls_pkg::OP_REVIVE: begin
               if (sel) begin
                  hb_in    = '0;
                  alive_in = 1'b1;
               end
            end
            lls_pkg::OP_DROP: begin
               if (sel) begin
                  valid_in = 1'b0;
               end
            end
            lls_pkg::OP_AGE: begin
               if (valid_ff) begin
                  hb_in = hb_up;
                  if (hb_up > hb_limit) begin
                     alive_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         token_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         token_ff <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      alive_ff   <= alive_in;
      key_ff     <= key_in;
      addr_ff    <= addr_in;
      port_ff    <= port_in;
      clients_ff <= clients_in;
      hb_ff      <= hb_in;
   end

endmodule

/* sv/least_loaded_server_table_core.sv */
`timescale 1ns / 1ps

// Server table for least-connections load balancing. Each of MAX_SERVERS cells holds
// one table entry; a command item sends a scan token down the row of cells, one cell
// per cycle, which gathers the key match, the first free slot and the least-loaded
// alive entry. The result is then broadcast back to the cells in one registered update.
// The token passes through the cell registers; the result is then held in the result
// registers while the update is applied, and the response register presents it. The
// block takes the next item once the response is presented, so items are handled one at
// a time; a response waits while the previous one is untaken. Every item yields exactly
// one response. heartbeat_limit is written through csr_wr_en / csr_wr_data and should
// only change while the block is idle.
module least_loaded_server_table_core #(
   parameter int MAX_SERVERS = lls_pkg::MAX_SERVERS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   lls_req_if.sink                    req_ch,
   lls_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [lls_pkg::HB_W-1:0]   csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [lls_pkg::HB_W-1:0]           hb_limit_ff;
   logic [lls_pkg::CMD_W-1:0]          cmd_ff, cmd_in;
   logic [lls_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [lls_pkg::PORT_W-1:0]         port_ff, port_in;
   lls_pkg::apply_type                 apply_ff, apply_in;

   logic                               res_ack_ff, res_ack_in;
   logic [lls_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [lls_pkg::ADDR_W-1:0]         res_addr_ff, res_addr_in;
   logic [lls_pkg::PORT_W-1:0]         res_port_ff, res_port_in;
   logic [lls_pkg::CLIENTS_W-1:0]      res_clients_ff, res_clients_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_ack_ff, rsp_ack_in;
   logic [lls_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [lls_pkg::ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [lls_pkg::PORT_W-1:0]         rsp_port_ff, rsp_port_in;
   logic [lls_pkg::CLIENTS_W-1:0]      rsp_clients_ff, rsp_clients_in;

   lls_pkg::token_type                 tok [0:MAX_SERVERS];
   lls_pkg::token_type                 tok_head;
   lls_pkg::token_type                 tail;
   logic                               accept;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      tok_head       = '0;
      tok_head.valid = accept;
      tok_head.key   = req_ch.conn_id;
   end

   assign tok[0] = tok_head;

   for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
      lls_cell #(
         .SLOT_IDX(lls_pkg::SLOT_W'(i))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_prev (tok[i]),
         .tok_next (tok[i+1]),
         .apply    (apply_ff),
         .hb_limit (hb_limit_ff)
      );
   end

   assign tail = tok[MAX_SERVERS];

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.ack              = rsp_ack_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.assigned_addr    = rsp_addr_ff;
   assign rsp_ch.assigned_port    = rsp_port_ff;
   assign rsp_ch.assigned_clients = rsp_clients_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      port_in        = port_ff;
      apply_in       = apply_ff;
      apply_in.en    = 1'b0;
      res_ack_in     = res_ack_ff;
      res_status_in  = res_status_ff;
      res_addr_in    = res_addr_ff;
      res_port_in    = res_port_ff;
      res_clients_in = res_clients_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_ack_in     = rsp_ack_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_clients_in = rsp_clients_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cmd_in   = req_ch.command;
               addr_in  = req_ch.server_addr;
               port_in  = req_ch.server_port;
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               state_in       = ST_DONE;
               apply_in.key   = tail.key;
               apply_in.addr  = addr_ff;
               apply_in.port  = port_ff;
               apply_in.idx   = tail.hit_idx;
               apply_in.op    = lls_pkg::OP_WRITE;
               res_ack_in     = 1'b0;
               res_status_in  = lls_pkg::ST_OK;
               res_addr_in    = '0;
               res_port_in    = '0;
               res_clients_in = '0;
               case (cmd_ff)
                  lls_pkg::CMD_REGISTER: begin
                     res_ack_in = 1'b1;
                     if (tail.hit) begin
                        apply_in.en = 1'b1;
                     end else if (tail.free) begin
                        apply_in.en  = 1'b1;
                        apply_in.idx = tail.free_idx;
                     end else begin
                        res_status_in = lls_pkg::ST_FULL;
                     end
                  end
                  lls_pkg::CMD_REQUEST: begin
                     res_ack_in = 1'b1;
                     if (tail.best) begin
                        apply_in.en  = 1'b1;
                        apply_in.op  = lls_pkg::OP_BUMP;
                        apply_in.idx = tail.best_idx;
                        res_addr_in  = tail.best_addr;
                        res_port_in  = tail.best_port;
                        res_clients_in = (tail.best_clients == lls_pkg::CLIENTS_MAX) ?
                                         tail.best_clients : tail.best_clients + 1'b1;
                     end else begin
                        res_status_in = lls_pkg::ST_NONE;
                     end
                  end
                  lls_pkg::CMD_KEEPALIVE: begin
                     res_ack_in  = 1'b1;
                     apply_in.en = tail.hit;
                     apply_in.op = lls_pkg::OP_REVIVE;
                  end
                  lls_pkg::CMD_DISCONNECT: begin
                     apply_in.en = tail.hit;
                     apply_in.op = lls_pkg::OP_DROP;
                  end
                  lls_pkg::CMD_TICK: begin
                     apply_in.en = 1'b1;
                     apply_in.op = lls_pkg::OP_AGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_ack_in     = res_ack_ff;
               rsp_status_in  = res_status_ff;
               rsp_addr_in    = res_addr_ff;
               rsp_port_in    = res_port_ff;
               rsp_clients_in = res_clients_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hb_limit_ff  <= lls_pkg::HB_LIMIT_RST;
         apply_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         apply_ff     <= apply_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            hb_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      addr_ff        <= addr_in;
      port_ff        <= port_in;
      res_ack_ff     <= res_ack_in;
      res_status_ff  <= res_status_in;
      res_addr_ff    <= res_addr_in;
      res_port_ff    <= res_port_in;
      res_clients_ff <= res_clients_in;
      rsp_ack_ff     <= rsp_ack_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_clients_ff <= rsp_clients_in;
   end

endmodule
